// ----- sv/fsc_pkg.sv -----
package fsc_pkg;

   localparam int PLANE_COUNT = 6;
   localparam int CFG_COUNT   = 8;
   localparam logic [2:0] NEAR_PLANE = 3'd4;
   localparam logic [2:0] NO_PLANE   = 3'd6;

   // step counts of the plane sequencer
   localparam logic [5:0] SQUARE_STEPS = 6'd3;
   localparam logic [5:0] ROOT_STEPS   = 6'd32;
   localparam logic [5:0] DIV_STEPS    = 6'd49;

   typedef logic [CFG_COUNT-1:0][63:0] mat_type;

   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [31:0] d;
   } plane_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [30:0]        radius;
      logic [2:0]         hint;
      logic [2:0]         cull;
      logic signed [31:0] nd;
   } item_type;

   typedef enum logic [2:0] {
      NS_IDLE, NS_LOAD, NS_PREP, NS_SQUARE, NS_ROOT, NS_DINIT, NS_DIVIDE, NS_STORE
   } norm_state_type;

   // identity matrix, one in Q16.16 on the diagonal
   localparam mat_type MAT_RESET = {
      64'h0001_0000_0000_0000, 64'h0,
      64'h0000_0000_0001_0000, 64'h0,
      64'h0,                   64'h0001_0000_0000_0000,
      64'h0,                   64'h0000_0000_0001_0000
   };

   // r and c count from zero
   function automatic logic signed [32:0] mat_entry(mat_type m, logic [1:0] r, logic [1:0] c);
      logic [63:0] w;
      logic [31:0] h;
      w = m[{r, c[1]}];
      h = c[0] ? w[63:32] : w[31:0];
      return 33'(signed'(h));
   endfunction

   // raw plane coefficient: r selects a, b, c or d
   function automatic logic signed [32:0] plane_raw(mat_type m, logic [2:0] p, logic [1:0] r);
      logic signed [32:0] e1, e2, e3, e4, res;
      e1 = mat_entry(m, r, 2'd0);
      e2 = mat_entry(m, r, 2'd1);
      e3 = mat_entry(m, r, 2'd2);
      e4 = mat_entry(m, r, 2'd3);
      case (p)
         3'd0: res = e4 - e2;
         3'd1: res = e4 + e2;
         3'd2: res = e4 + e1;
         3'd3: res = e4 - e1;
         3'd4: res = e3;
         3'd5: res = e4 - e3;
         default: res = '0;
      endcase
      return res;
   endfunction

   function automatic logic [32:0] mag33(logic signed [32:0] v);
      return v[32] ? 33'(-v) : 33'(v);
   endfunction

   function automatic logic signed [31:0] sat_mag(logic neg, logic [48:0] m);
      logic signed [31:0] res;
      if (neg) begin
         if (m >= 49'h0_8000_0000) res = 32'sh8000_0000;
         else res = signed'(~m[31:0] + 32'd1);
      end else begin
         if (m > 49'h0_7FFF_FFFF) res = 32'sh7FFF_FFFF;
         else res = signed'(m[31:0]);
      end
      return res;
   endfunction

endpackage

// ----- sv/fsc_norm.sv -----
module fsc_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  fsc_pkg::mat_type      mat,
   output fsc_pkg::plane_type    planes [fsc_pkg::PLANE_COUNT],
   output logic                  busy
);

   fsc_pkg::norm_state_type state_ff, state_in;
   logic [2:0]         plane_ff, plane_in;
   logic [1:0]         coef_ff, coef_in;
   logic [5:0]         step_ff, step_in;
   logic signed [32:0] raw_ff [4];
   logic [30:0]        sm_ff [3];
   logic [1:0]         sh_ff;
   logic [63:0]        acc_ff;
   logic [63:0]        root_ff;
   logic [63:0]        bit_ff;
   logic [33:0]        den_ff;
   logic [33:0]        rem_ff;
   logic [48:0]        num_ff;
   logic signed [31:0] store_ff [fsc_pkg::PLANE_COUNT][4];

   logic [32:0] mag_a, mag_b, mag_c, mag_max, mag_d;
   logic [1:0]  sh_calc;
   logic [61:0] sq;
   logic [63:0] trial_root;
   logic [34:0] trial_div;
   logic        div_ge;
   logic [31:0] len;
   logic signed [31:0] coef_val;
   logic        last_step;

   assign len = root_ff[31:0];
   assign mag_a = fsc_pkg::mag33(raw_ff[0]);
   assign mag_b = fsc_pkg::mag33(raw_ff[1]);
   assign mag_c = fsc_pkg::mag33(raw_ff[2]);
   assign mag_d = fsc_pkg::mag33(raw_ff[3]);

   always_comb begin
      mag_max = mag_a;
      if (mag_b > mag_max) mag_max = mag_b;
      if (mag_c > mag_max) mag_max = mag_c;
      if (mag_max[32]) sh_calc = 2'd2;
      else if (mag_max[31]) sh_calc = 2'd1;
      else sh_calc = 2'd0;
   end

   assign sq         = sm_ff[step_ff[1:0]] * sm_ff[step_ff[1:0]];
   assign trial_root = root_ff + bit_ff;
   assign trial_div  = {rem_ff, num_ff[48]};
   assign div_ge     = trial_div >= {1'b0, den_ff};

   always_comb begin
      case (state_ff)
         fsc_pkg::NS_SQUARE: last_step = step_ff == fsc_pkg::SQUARE_STEPS - 6'd1;
         fsc_pkg::NS_ROOT:   last_step = step_ff == fsc_pkg::ROOT_STEPS - 6'd1;
         fsc_pkg::NS_DIVIDE: last_step = step_ff == fsc_pkg::DIV_STEPS - 6'd1;
         default:            last_step = 1'b1;
      endcase
   end

   // value written back: degenerate plane keeps only the raw d
   always_comb begin
      if (len == 32'd0) begin
         if (coef_ff == 2'd3) coef_val = fsc_pkg::sat_mag(raw_ff[3][32], 49'(mag_d));
         else coef_val = '0;
      end else begin
         coef_val = fsc_pkg::sat_mag(raw_ff[coef_ff][32], num_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      plane_in = plane_ff;
      coef_in  = coef_ff;
      step_in  = step_ff;
      case (state_ff)
         fsc_pkg::NS_IDLE: ;
         fsc_pkg::NS_LOAD: state_in = fsc_pkg::NS_PREP;
         fsc_pkg::NS_PREP: begin
            state_in = fsc_pkg::NS_SQUARE;
            step_in  = '0;
         end
         fsc_pkg::NS_SQUARE, fsc_pkg::NS_ROOT: begin
            step_in = step_ff + 6'd1;
            if (last_step) begin
               step_in  = '0;
               state_in = (state_ff == fsc_pkg::NS_SQUARE) ? fsc_pkg::NS_ROOT
                                                           : fsc_pkg::NS_DINIT;
               coef_in  = '0;
            end
         end
         fsc_pkg::NS_DINIT: begin
            state_in = fsc_pkg::NS_DIVIDE;
            step_in  = '0;
         end
         fsc_pkg::NS_DIVIDE: begin
            step_in = step_ff + 6'd1;
            if (last_step) state_in = fsc_pkg::NS_STORE;
         end
         fsc_pkg::NS_STORE: begin
            if (coef_ff != 2'd3) begin
               coef_in  = coef_ff + 2'd1;
               state_in = fsc_pkg::NS_DINIT;
            end else if (plane_ff != 3'(fsc_pkg::PLANE_COUNT - 1)) begin
               plane_in = plane_ff + 3'd1;
               state_in = fsc_pkg::NS_LOAD;
            end else begin
               state_in = fsc_pkg::NS_IDLE;
            end
         end
         default: state_in = fsc_pkg::NS_IDLE;
      endcase
      if (restart) begin
         state_in = fsc_pkg::NS_LOAD;
         plane_in = '0;
      end
   end

   // outputs
   always_comb begin
      busy = state_ff != fsc_pkg::NS_IDLE;
      for (int p = 0; p < fsc_pkg::PLANE_COUNT; p++) begin
         planes[p].a = store_ff[p][0];
         planes[p].b = store_ff[p][1];
         planes[p].c = store_ff[p][2];
         planes[p].d = store_ff[p][3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsc_pkg::NS_LOAD;
         plane_ff <= '0;
         coef_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         plane_ff <= plane_in;
         coef_ff  <= coef_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         fsc_pkg::NS_LOAD: begin
            for (int r = 0; r < 4; r++) raw_ff[r] <= fsc_pkg::plane_raw(mat, plane_ff, 2'(r));
         end
         fsc_pkg::NS_PREP: begin
            sh_ff    <= sh_calc;
            sm_ff[0] <= 31'(mag_a >> sh_calc);
            sm_ff[1] <= 31'(mag_b >> sh_calc);
            sm_ff[2] <= 31'(mag_c >> sh_calc);
            acc_ff   <= '0;
            root_ff  <= '0;
            bit_ff   <= 64'h4000_0000_0000_0000;
         end
         fsc_pkg::NS_SQUARE: acc_ff <= acc_ff + 64'(sq);
         fsc_pkg::NS_ROOT: begin
            if (acc_ff >= trial_root) begin
               acc_ff  <= acc_ff - trial_root;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         fsc_pkg::NS_DINIT: begin
            rem_ff <= '0;
            if (coef_ff == 2'd3) begin
               num_ff <= {mag_d, 16'h0};
               den_ff <= 34'(len) << sh_ff;
            end else begin
               num_ff <= {2'b00, sm_ff[coef_ff], 16'h0};
               den_ff <= 34'(len);
            end
         end
         fsc_pkg::NS_DIVIDE: begin
            rem_ff <= div_ge ? 34'(trial_div - {1'b0, den_ff}) : trial_div[33:0];
            num_ff <= {num_ff[47:0], div_ge};
         end
         fsc_pkg::NS_STORE: store_ff[plane_ff][coef_ff] <= coef_val;
         default: ;
      endcase
   end

endmodule

// ----- sv/fsc_cell.sv -----
module fsc_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         cell_index,
   input  fsc_pkg::plane_type plane,
   input  logic               in_valid,
   input  fsc_pkg::item_type  in_item,
   output logic               in_ready,
   output logic               out_valid,
   output fsc_pkg::item_type  out_item,
   input  logic               out_ready
);

   // stage a: products, stage b: sum, compare, verdict
   logic               a_valid_ff, b_valid_ff;
   fsc_pkg::item_type  a_item_ff, b_item_ff, b_item_in;
   logic signed [63:0] pa_ff, pb_ff, pc_ff;
   logic signed [31:0] pd_ff;
   logic               a_ready, b_ready;
   logic signed [65:0] dist_sum, bound, q;
   logic               rej;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign dist_sum = 66'(pa_ff) + 66'(pb_ff) + 66'(pc_ff) + (66'(pd_ff) <<< 16);
   assign bound    = dist_sum + signed'({19'b0, a_item_ff.radius, 16'b0});
   assign rej      = bound[65] || (bound == '0);
   assign q        = dist_sum >>> 16;

   always_comb begin
      b_item_in = a_item_ff;
      // hint plane wins outright; otherwise first rejecting plane
      if (rej && (a_item_ff.hint == cell_index || a_item_ff.cull == fsc_pkg::NO_PLANE))
         b_item_in.cull = cell_index;
      if (cell_index == fsc_pkg::NEAR_PLANE) begin
         if (q > 66'sd2147483647) b_item_in.nd = 32'sh7FFF_FFFF;
         else if (q < -66'sd2147483648) b_item_in.nd = 32'sh8000_0000;
         else b_item_in.nd = q[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_item_ff <= in_item;
         pa_ff     <= plane.a * in_item.x;
         pb_ff     <= plane.b * in_item.y;
         pc_ff     <= plane.c * in_item.z;
         pd_ff     <= plane.d;
      end
      if (b_ready && a_valid_ff) b_item_ff <= b_item_in;
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

// ----- sv/frustum_sphere_cull.sv -----
// Each accepted item passes two stages per plane cell, six cells; the chain holds up to twelve
// items in flight. Throughput: one item per cycle while rsp_tready is high and no rebuild runs.
// Reset: synchronous, active high; matrix returns to identity, then the plane sequencer
// rebuilds the six planes with req_tready low. Every csr write restarts that same rebuild,
// which runs on the one shared bit-serial root/divide unit.
module frustum_sphere_cull (
   input  logic          clock,
   input  logic          reset,
   // item in
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [135:0]  req_tdata,  // center_x, center_y, center_z, radius, hint_plane, zero pad
   // item out
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [39:0]   rsp_tdata,  // visible, culling_plane, near_distance, zero pad
   // register writes
   input  logic          csr_wen,
   input  logic [2:0]    csr_index,
   input  logic [63:0]   csr_wdata
);

   fsc_pkg::mat_type   mat_ff;
   fsc_pkg::plane_type planes [fsc_pkg::PLANE_COUNT];
   logic               busy;

   // chain links: link k feeds cell k
   logic              link_valid [fsc_pkg::PLANE_COUNT+1];
   logic              link_ready [fsc_pkg::PLANE_COUNT+1];
   fsc_pkg::item_type link_item  [fsc_pkg::PLANE_COUNT+1];

   // matrix registers, two Q16.16 entries per word
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= fsc_pkg::MAT_RESET;
      end else if (csr_wen) begin
         mat_ff[csr_index] <= csr_wdata;
      end
   end

   // plane extraction and normalisation, restarted by any write
   fsc_norm u_norm (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_wen),
      .mat     (mat_ff),
      .planes  (planes),
      .busy    (busy)
   );

   // new item enters with no rejecting plane yet
   always_comb begin
      link_item[0].x      = signed'(req_tdata[31:0]);
      link_item[0].y      = signed'(req_tdata[63:32]);
      link_item[0].z      = signed'(req_tdata[95:64]);
      link_item[0].radius = req_tdata[126:96];
      link_item[0].hint   = req_tdata[129:127];
      link_item[0].cull   = fsc_pkg::NO_PLANE;
      link_item[0].nd     = '0;
   end

   assign link_valid[0] = req_tvalid && !busy;
   assign req_tready    = link_ready[0] && !busy;

   // one cell per plane; each tests the item against its own plane and passes it on
   for (genvar g = 0; g < fsc_pkg::PLANE_COUNT; g++) begin : g_cell
      fsc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (3'(g)),
         .plane      (planes[g]),
         .in_valid   (link_valid[g]),
         .in_item    (link_item[g]),
         .in_ready   (link_ready[g]),
         .out_valid  (link_valid[g+1]),
         .out_item   (link_item[g+1]),
         .out_ready  (link_ready[g+1])
      );
   end

   // last cell's stage b is the output register
   assign rsp_tvalid = link_valid[fsc_pkg::PLANE_COUNT];
   assign link_ready[fsc_pkg::PLANE_COUNT] = rsp_tready;
   assign rsp_tdata  = {4'b0,
                        link_item[fsc_pkg::PLANE_COUNT].nd,
                        link_item[fsc_pkg::PLANE_COUNT].cull,
                        link_item[fsc_pkg::PLANE_COUNT].cull == fsc_pkg::NO_PLANE};

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import fsc_pkg::*;

   // plane numbering, near and none come from the package
   localparam logic [2:0] PL_TOP    = 3'd0;
   localparam logic [2:0] PL_BOTTOM = 3'd1;
   localparam logic [2:0] PL_LEFT   = 3'd2;
   localparam logic [2:0] PL_RIGHT  = 3'd3;
   localparam logic [2:0] PL_FAR    = 3'd5;
   localparam logic [2:0] HINT_BAD  = 3'd7;   // out of range, acts as no hint

   localparam int ONE        = 65536;         // 1.0 in Q16.16
   localparam int STALL_MAX  = 20000;         // idle cycles before giving up
   localparam int RANDOM_N   = 1750;
   localparam int SETTINGS_N = 10;

   typedef struct {
      logic signed [31:0] x, y, z;
      logic [30:0]        radius;
      logic [2:0]         hint;
   } sphere_t;

   typedef struct {
      logic               vis;
      logic [2:0]         cull;
      logic signed [31:0] nd;
   } verdict_t;

   typedef struct {
      sphere_t  s;
      bit       known;       // verdict typed in by hand
      verdict_t v;
   } row_t;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [135:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [39:0]   rsp_tdata;
   logic          csr_wen = 1'b0;
   logic [2:0]    csr_index = '0;
   logic [63:0]   csr_wdata = '0;

   frustum_sphere_cull i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Own copy of matrix and plane table
   // ---------------------------------------------------------------
   logic [63:0]        matrix [CFG_COUNT];
   logic signed [31:0] planes [PLANE_COUNT*4];

   verdict_t pending [$];   // verdicts owed by the block, oldest first
   row_t     directed [$];
   int       errors = 0;
   int       items_in = 0;
   int       items_out = 0;
   int       culled_n = 0;
   int       idle_cycles = 0;

   function automatic logic signed [31:0] clamp32(bit neg, longint unsigned m);
      if (neg) return (m >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-longint'(m));
      return (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(m);
   endfunction

   function automatic longint unsigned abs64(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   -= res + bitv;
            res  = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // element m(r,c), r and c from 1
   function automatic longint elem(int r, int c);
      logic [63:0] w;
      logic [31:0] h;
      w = matrix[(r - 1) * 2 + (c - 1) / 2];
      h = ((c - 1) % 2 == 1) ? w[63:32] : w[31:0];
      return longint'(signed'(h));
   endfunction

   function automatic void put_plane(int i, longint a, longint b, longint c, longint d);
      longint          raw [3];
      longint unsigned sm [3];
      longint unsigned m, s, len;
      int              sh;
      raw[0] = a; raw[1] = b; raw[2] = c;
      m = abs64(a);
      if (abs64(b) > m) m = abs64(b);
      if (abs64(c) > m) m = abs64(c);
      sh = 0;
      while ((m >> sh) >= 64'h8000_0000) sh++;
      s = 0;
      for (int k = 0; k < 3; k++) begin
         sm[k] = abs64(raw[k]) >> sh;
         s += sm[k] * sm[k];
      end
      len = root64(s);
      if (len == 0) begin
         // degenerate plane: normal zero, d kept raw
         for (int k = 0; k < 3; k++) planes[i*4 + k] = '0;
         planes[i*4 + 3] = clamp32(d < 0, abs64(d));
      end else begin
         for (int k = 0; k < 3; k++)
            planes[i*4 + k] = clamp32(raw[k] < 0, (sm[k] << 16) / len);
         planes[i*4 + 3] = clamp32(d < 0, (abs64(d) << 16) / (len << sh));
      end
   endfunction

   function automatic void derive_planes();
      longint col [5][5];
      for (int r = 1; r <= 4; r++)
         for (int c = 1; c <= 4; c++) col[c][r] = elem(r, c);
      put_plane(0, col[4][1]-col[2][1], col[4][2]-col[2][2], col[4][3]-col[2][3],
                col[4][4]-col[2][4]);
      put_plane(1, col[4][1]+col[2][1], col[4][2]+col[2][2], col[4][3]+col[2][3],
                col[4][4]+col[2][4]);
      put_plane(2, col[4][1]+col[1][1], col[4][2]+col[1][2], col[4][3]+col[1][3],
                col[4][4]+col[1][4]);
      put_plane(3, col[4][1]-col[1][1], col[4][2]-col[1][2], col[4][3]-col[1][3],
                col[4][4]-col[1][4]);
      put_plane(4, col[3][1], col[3][2], col[3][3], col[3][4]);
      put_plane(5, col[4][1]-col[3][1], col[4][2]-col[3][2], col[4][3]-col[3][3],
                col[4][4]-col[3][4]);
   endfunction

   // exact signed distance, Q32.32
   function automatic longint plane_dist(int i, sphere_t s);
      return longint'(planes[i*4]) * longint'(s.x) + longint'(planes[i*4+1]) * longint'(s.y)
           + longint'(planes[i*4+2]) * longint'(s.z) + longint'(planes[i*4+3]) * 65536;
   endfunction

   function automatic verdict_t cull_sphere(sphere_t s);
      verdict_t        v;
      longint          limit, nd;
      logic [2:0]      hit;
      longint unsigned q;
      limit = -(longint'(s.radius) << 16);
      hit   = NO_PLANE;
      // hinted plane goes first, then the rest in order
      if (s.hint < PLANE_COUNT && plane_dist(s.hint, s) <= limit) hit = s.hint;
      for (int i = 0; i < PLANE_COUNT && hit == NO_PLANE; i++)
         if (i != s.hint && plane_dist(i, s) <= limit) hit = 3'(i);
      nd = plane_dist(NEAR_PLANE, s);
      if (nd < 0) begin
         q    = (longint'(-nd) + 65535) >> 16;   // floor of a negative value
         v.nd = clamp32(1'b1, q);
      end else begin
         q    = nd >> 16;
         v.nd = clamp32(1'b0, q);
      end
      v.vis  = (hit == NO_PLANE);
      v.cull = hit;
      return v;
   endfunction

   // ---------------------------------------------------------------
   // Result side: stall pattern, checking, watchdog
   // ---------------------------------------------------------------
   int stall_pct = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      verdict_t w;
      if (stall_left == 0) begin
         // new stall regime: often none, sometimes heavy
         stall_left <= $urandom_range(50, 300);
         case ($urandom_range(0, 3))
            0: stall_pct <= 0;
            1: stall_pct <= 20;
            2: stall_pct <= 50;
            default: stall_pct <= 85;
         endcase
      end else begin
         stall_left <= stall_left - 1;
      end
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);

      if (rsp_tvalid && rsp_tready) begin
         items_out++;
         if (pending.size() == 0) begin
            $display("%0t: item out with none expected, got vis %0b plane %0d nd %0d",
                     $time, rsp_tdata[0], rsp_tdata[3:1], $signed(rsp_tdata[35:4]));
            errors++;
         end else begin
            w = pending.pop_front();
            if (!w.vis) culled_n++;
            if (rsp_tdata[0] !== w.vis) begin
               $display("%0t: visible expected %0b actual %0b", $time, w.vis, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[3:1] !== w.cull) begin
               $display("%0t: culling_plane expected %0d actual %0d",
                        $time, w.cull, rsp_tdata[3:1]);
               errors++;
            end
            if (rsp_tdata[35:4] !== w.nd) begin
               $display("%0t: near_distance expected %0d actual %0d",
                        $time, w.nd, $signed(rsp_tdata[35:4]));
               errors++;
            end
         end
      end

      // watchdog: any handshake on either side, or a csr write, resets it
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_MAX) begin
         $display("watchdog: no progress for %0d cycles", STALL_MAX);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus side
   // ---------------------------------------------------------------
   task automatic drain();
      while (pending.size() != 0) @(posedge clock);
   endtask

   // one item; tvalid stays high afterwards, the caller lowers it for a gap
   task automatic send(sphere_t s, bit known, verdict_t v);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, s.hint, s.radius, s.z, s.y, s.x};
      do @(posedge clock); while (!req_tready);
      pending.push_back(known ? v : cull_sphere(s));
      items_in++;
   endtask

   task automatic pause_sender();
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // whole matrix, written only with the block drained
   task automatic load_matrix(logic [63:0] m [CFG_COUNT]);
      req_tvalid <= 1'b0;
      drain();
      repeat (20) @(posedge clock);
      for (int i = 0; i < CFG_COUNT; i++) begin
         csr_wen   <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= m[i];
         @(posedge clock);
         matrix[i] = m[i];
      end
      csr_wen <= 1'b0;
      derive_planes();
   endtask

   function automatic logic [31:0] pick_entry(int kind);
      case (kind)
         0: return 32'($urandom_range(0, 4 * ONE)) - 32'(2 * ONE);  // within +-2.0
         1: return $urandom;
         2: return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return ($urandom_range(0, 2) == 0) ? 32'h0 : 32'(ONE);
      endcase
   endfunction

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return 32'($urandom_range(0, 64 * ONE)) - 32'(32 * ONE);
         default: return 32'($urandom_range(0, 4 * ONE)) - 32'(2 * ONE);
      endcase
   endfunction

   function automatic sphere_t pick_sphere();
      sphere_t s;
      s.x = pick_coord();
      s.y = pick_coord();
      s.z = pick_coord();
      case ($urandom_range(0, 4))
         0: s.radius = '0;                             // point test
         1: s.radius = 31'($urandom);
         2: s.radius = 31'($urandom_range(0, ONE));
         default: s.radius = 31'($urandom_range(0, 8 * ONE));
      endcase
      s.hint = 3'($urandom_range(0, 7));
      return s;
   endfunction

   task automatic add_row(int x, int y, int z, int r, logic [2:0] h,
                          bit known, logic vis, logic [2:0] pl, int nd);
      row_t t;
      t.s.x = x; t.s.y = y; t.s.z = z; t.s.radius = 31'(r); t.s.hint = h;
      t.known = known;
      t.v.vis = vis; t.v.cull = pl; t.v.nd = nd;
      directed.push_back(t);
   endtask

   initial begin
      logic [63:0] m [CFG_COUNT];
      sphere_t     s;
      verdict_t    none;
      int          per_set, burst;

      none = '{1'b0, 3'd0, 32'sd0};
      // identity after reset
      matrix = '{64'd65536, 64'd0, 64'd65536 << 32, 64'd0,
                 64'd0, 64'd65536, 64'd0, 64'd65536 << 32};
      derive_planes();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: identity frustum is the cube |x|,|y| <= 1, 0 <= z <= 1
      add_row(0, 0, 0, 0, NO_PLANE, 1, 1'b0, NEAR_PLANE, 0);          // point on near plane
      add_row(0, 0, ONE/2, 0, NEAR_PLANE, 1, 1'b1, NO_PLANE, ONE/2);
      add_row(0, 2*ONE, ONE/2, 0, NO_PLANE, 1, 1'b0, PL_TOP, ONE/2);
      add_row(0, 2*ONE, ONE/2, 0, PL_BOTTOM, 1, 1'b0, PL_TOP, ONE/2);
      add_row(0, 2*ONE, -ONE, 0, NEAR_PLANE, 1, 1'b0, NEAR_PLANE, -ONE); // hint wins
      add_row(0, 2*ONE, -ONE, 0, HINT_BAD, 1, 1'b0, PL_TOP, -ONE);
      add_row(32'h7FFF_FFFF, 0, ONE/2, 0, NO_PLANE, 1, 1'b0, PL_RIGHT, ONE/2);
      add_row(32'h8000_0000, 0, ONE/2, 0, NO_PLANE, 1, 1'b0, PL_LEFT, ONE/2);
      add_row(0, 0, 32'h7FFF_FFFF, 0, NO_PLANE, 1, 1'b0, PL_FAR, 32'h7FFF_FFFF);
      add_row(0, 0, 32'h8000_0000, 0, NO_PLANE, 1, 1'b0, NEAR_PLANE, 32'h8000_0000);
      add_row(0, 0, 0, 32'h7FFF_FFFF, PL_TOP, 1, 1'b1, NO_PLANE, 0);  // huge radius
      add_row(0, 3*ONE, 0, ONE, PL_FAR, 1, 1'b0, PL_TOP, 0);
      add_row(0, 2*ONE, 0, ONE, NO_PLANE, 1, 1'b0, PL_TOP, 0);        // just touching
      add_row(0, 2*ONE, 0, ONE + 1, NO_PLANE, 1, 1'b1, NO_PLANE, 0);  // one lsb clear
      add_row(-ONE/3, ONE/5, -7, 0, PL_LEFT, 0, 1'b0, 3'd0, 0);
      add_row(3*ONE, -3*ONE, 2*ONE, ONE/2, PL_RIGHT, 0, 1'b0, 3'd0, 0);
      add_row(-1, -1, -1, 1, PL_BOTTOM, 0, 1'b0, 3'd0, 0);
      add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, PL_FAR,
              0, 1'b0, 3'd0, 0);

      foreach (directed[i]) begin
         send(directed[i].s, directed[i].known, directed[i].v);
         if (i % 5 == 4) pause_sender();
      end

      // random part over a series of matrices, extremes first
      per_set = RANDOM_N / SETTINGS_N;
      for (int setting = 0; setting < SETTINGS_N; setting++) begin
         for (int i = 0; i < CFG_COUNT; i++) begin
            case (setting)
               0: m[i] = '0;                                   // every plane degenerate
               1: m[i] = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
               2: m[i] = {32'h8000_0000, 32'h8000_0000};
               3: m[i] = {pick_entry(2), pick_entry(2)};
               4: m[i] = {pick_entry(1), pick_entry(1)};
               5: m[i] = {pick_entry(3), pick_entry(3)};
               default: m[i] = {pick_entry(0), pick_entry(0)};
            endcase
         end
         load_matrix(m);
         burst = 0;
         for (int n = 0; n < per_set; n++) begin
            s = pick_sphere();
            send(s, 0, none);
            // hold off once, mid run, until the block is empty
            if (setting == SETTINGS_N / 2 && n == per_set / 2) begin
               req_tvalid <= 1'b0;
               drain();
               @(posedge clock);
            end else if (burst == 0) begin
               burst = $urandom_range(1, 24);
               if (setting % 3 != 1) pause_sender();   // some settings stream flat out
            end else begin
               burst--;
            end
         end
      end
      req_tvalid <= 1'b0;

      drain();
      repeat (30) @(posedge clock);

      $display("%0d spheres sent, %0d verdicts checked, %0d culled", items_in, items_out,
               culled_n);
      $display("covered reset identity, %0d matrix settings incl. zero and full-scale",
               SETTINGS_N);
      if (errors == 0 && pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/fsc_pkg.sv
sv/fsc_norm.sv
sv/fsc_cell.sv
sv/frustum_sphere_cull.sv
sim/tb.sv
